[hdl/sliding_window_maximum_assert.svh]
// Assertion macros for the sliding window maximum block.
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

// Same-cycle implication.
`define SWM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/sldmx_pkg.sv]
// Shared constants and types for the sliding window maximum block.
package sldmx_pkg;

   localparam int WINDOW_MAX_DEF  = 256;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int LEN_W           = 9;
   localparam logic [LEN_W-1:0] LEN_RESET = 9'd20;

   typedef enum logic [1:0] {
      OP_WARM,
      OP_CUM,
      OP_WIN
   } op_type;

   typedef struct packed {
      op_type op;
      logic   first;
   } cmd_type;

endpackage

[hdl/sliding_window_maximum.sv]
// Top level of the sliding window maximum block.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  sample, in_warmup, first_of_series
//   rsp      out        rsp_valid/rsp_stall  window_max, result_valid
//   csr      in         csr_valid/csr_ready  window_length
//
// Warm-up and cumulative items go straight to the back end's done state;
// windowed items first pass the head and tail states, which drop candidates
// from either end of the candidate queue one at a time, as the candidate RAM
// has one read port. A two-entry queue decouples acceptance from the back end.
// Synchronous reset; window_length resets to 20. Either side may stall freely.
module sliding_window_maximum #(
   parameter int WINDOW_MAX  = sldmx_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = sldmx_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_sample,
   input  logic                              req_in_warmup,
   input  logic                              req_first_of_series,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SAMPLE_BITS-1:0]            rsp_window_max,
   output logic                              rsp_result_valid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sldmx_pkg::LEN_W-1:0]       csr_window_length
);

   import sldmx_pkg::*;

   logic [LEN_W-1:0]       window_length_ff;
   logic                   csr_write;
   logic                   cmd_valid;
   logic                   cmd_ready;
   cmd_type                cmd;
   logic [SAMPLE_BITS-1:0] cmd_sample;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= LEN_RESET;
      end else if (csr_write) begin
         window_length_ff <= csr_window_length;
      end
   end

   sldmx_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_in_warmup       (req_in_warmup),
      .req_first_of_series (req_first_of_series),
      .window_length       (window_length_ff),
      .cmd_valid           (cmd_valid),
      .cmd_ready           (cmd_ready),
      .cmd                 (cmd),
      .cmd_sample          (cmd_sample)
   );

   sldmx_back #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .clear            (csr_write),
      .window_length    (window_length_ff),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd),
      .cmd_sample       (cmd_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_max   (rsp_window_max),
      .rsp_result_valid (rsp_result_valid)
   );

endmodule

[hdl/sldmx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sldmx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sldmx_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
module sldmx_front #(
   parameter int SAMPLE_BITS = sldmx_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [SAMPLE_BITS-1:0]            req_sample,
   input  logic                              req_in_warmup,
   input  logic                              req_first_of_series,
   input  logic [sldmx_pkg::LEN_W-1:0]       window_length,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output sldmx_pkg::cmd_type                cmd,
   output logic [SAMPLE_BITS-1:0]            cmd_sample
);

   import sldmx_pkg::*;

   localparam int DEPTH = 2;

   cmd_type                q_cmd_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] q_smp_ff [DEPTH];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             cnt_ff;
   logic                   push;
   logic                   pop;
   cmd_type                in_cmd;

   assign req_stall = (cnt_ff == 2'(DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      in_cmd.first = req_first_of_series;
      if (req_in_warmup) begin
         in_cmd.op = OP_WARM;
      end else if (window_length == '0) begin
         in_cmd.op = OP_CUM;
      end else begin
         in_cmd.op = OP_WIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
      if (push) begin
         q_cmd_ff[wr_ptr_ff] <= in_cmd;
         q_smp_ff[wr_ptr_ff] <= req_sample;
      end
   end

   assign cmd        = q_cmd_ff[rd_ptr_ff];
   assign cmd_sample = q_smp_ff[rd_ptr_ff];

endmodule

[hdl/sldmx_back.sv]
// Back end: candidate queue maintenance, running maximum and result register.
module sldmx_back #(
   parameter int WINDOW_MAX  = sldmx_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = sldmx_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic [sldmx_pkg::LEN_W-1:0]       window_length,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  sldmx_pkg::cmd_type                cmd,
   input  logic [SAMPLE_BITS-1:0]            cmd_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SAMPLE_BITS-1:0]            rsp_window_max,
   output logic                              rsp_result_valid
);

   import sldmx_pkg::*;

   localparam int HEAD_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int POS_MOD = 2 * WINDOW_MAX;
   localparam int POS_W   = $clog2(POS_MOD);
   localparam int CMP_W   = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;
   localparam int ENT_W   = SAMPLE_BITS + POS_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HEAD,
      S_TAIL,
      S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [HEAD_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [POS_W-1:0]         arrival_ff, arrival_in;
   logic [LEN_W-1:0]         seen_ff, seen_in;
   logic signed [SAMPLE_BITS-1:0] run_ff, run_in;
   logic signed [SAMPLE_BITS-1:0] headv_ff, headv_in;
   logic signed [SAMPLE_BITS-1:0] key_ff, key_in;
   logic [SAMPLE_BITS-1:0]   res_max_ff, res_max_in;
   logic                     res_ok_ff, res_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]   rsp_max_ff, rsp_max_in;
   logic                     rsp_ok_ff, rsp_ok_in;

   logic                     ram_we;
   logic [HEAD_W-1:0]        ram_raddr;
   logic [ENT_W-1:0]         ram_rdata;
   logic signed [SAMPLE_BITS-1:0] rd_val;
   logic [POS_W-1:0]         rd_pos;
   logic [POS_W:0]           pos_diff;
   logic [POS_W-1:0]         age;
   logic [CMP_W-1:0]         len_eff;
   logic [HEAD_W-1:0]        head_inc;
   logic [HEAD_W-1:0]        tail_slot;
   logic [HEAD_W-1:0]        tail2_slot;
   logic [HEAD_W-1:0]        push_slot;
   logic [POS_W-1:0]         arrival_nxt;
   logic [HEAD_W-1:0]        base_head;
   logic [CNT_W-1:0]         base_count;
   logic [POS_W-1:0]         base_arrival;
   logic [LEN_W-1:0]         base_seen;
   logic signed [SAMPLE_BITS-1:0] base_run;
   logic signed [SAMPLE_BITS-1:0] cum_max;
   logic [LEN_W-1:0]         seen_nxt;
   logic                     win_ok;
   logic signed [SAMPLE_BITS-1:0] best;
   logic                     out_free;

   function automatic logic [HEAD_W-1:0] slot(input logic [HEAD_W-1:0] h,
                                              input logic [CNT_W-1:0]  k);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(h) + (CNT_W+1)'(k);
      if (s >= (CNT_W+1)'(WINDOW_MAX)) begin
         s = s - (CNT_W+1)'(WINDOW_MAX);
      end
      return HEAD_W'(s);
   endfunction

   sldmx_ram #(
      .WIDTH (ENT_W),
      .DEPTH (WINDOW_MAX)
   ) u_cand_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (push_slot),
      .wr_data ({key_ff, arrival_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_val   = $signed(ram_rdata[ENT_W-1:POS_W]);
   assign rd_pos   = ram_rdata[POS_W-1:0];
   assign pos_diff = {1'b0, arrival_ff} - {1'b0, rd_pos};
   assign age      = pos_diff[POS_W] ? POS_W'(pos_diff + (POS_W+1)'(POS_MOD))
                                     : pos_diff[POS_W-1:0];
   assign len_eff  = (CMP_W'(window_length) > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX)
                                                                  : CMP_W'(window_length);

   assign head_inc   = slot(head_ff, CNT_W'(1));
   assign tail_slot  = slot(head_ff, count_ff - CNT_W'(1));
   assign tail2_slot = slot(head_ff, count_ff - CNT_W'(2));
   assign push_slot  = slot(head_ff, count_ff);
   assign arrival_nxt = (arrival_ff == POS_W'(POS_MOD - 1)) ? '0 : arrival_ff + POS_W'(1);

   // first of series clears the window before the sample is taken
   assign base_head    = cmd.first ? '0 : head_ff;
   assign base_count   = cmd.first ? '0 : count_ff;
   assign base_arrival = cmd.first ? '0 : arrival_ff;
   assign base_seen    = cmd.first ? '0 : seen_ff;
   assign base_run     = cmd.first ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : run_ff;
   assign cum_max      = (base_seen == '0 || $signed(cmd_sample) > base_run)
                         ? $signed(cmd_sample) : base_run;

   assign seen_nxt = (CMP_W'(seen_ff) < len_eff) ? seen_ff + LEN_W'(1) : seen_ff;
   assign win_ok   = (CMP_W'(seen_nxt) >= len_eff);
   assign best     = (count_ff == '0) ? key_ff : headv_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      arrival_in   = arrival_ff;
      seen_in      = seen_ff;
      run_in       = run_ff;
      headv_in     = headv_ff;
      key_in       = key_ff;
      res_max_in   = res_max_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_ok_in    = rsp_ok_ff;
      ram_we       = 1'b0;
      ram_raddr    = head_ff;
      cmd_ready    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            ram_raddr = base_head;
            if (cmd_valid) begin
               key_in     = $signed(cmd_sample);
               head_in    = base_head;
               count_in   = base_count;
               arrival_in = base_arrival;
               seen_in    = base_seen;
               run_in     = base_run;
               case (cmd.op)
                  OP_CUM: begin
                     run_in     = cum_max;
                     seen_in    = LEN_W'(1);
                     res_max_in = cum_max;
                     res_ok_in  = 1'b1;
                     state_in   = S_DONE;
                  end
                  OP_WIN: begin
                     state_in = S_HEAD;
                  end
                  default: begin
                     res_max_in = '0;
                     res_ok_in  = 1'b0;
                     state_in   = S_DONE;
                  end
               endcase
            end
         end
         S_HEAD: begin
            if (count_ff != '0 && CMP_W'(age) >= len_eff) begin
               head_in   = head_inc;
               count_in  = count_ff - CNT_W'(1);
               ram_raddr = head_inc;
            end else begin
               headv_in  = rd_val;
               ram_raddr = tail_slot;
               state_in  = S_TAIL;
            end
         end
         S_TAIL: begin
            if (count_ff != '0 && rd_val <= key_ff) begin
               count_in  = count_ff - CNT_W'(1);
               ram_raddr = tail2_slot;
            end else begin
               if (count_ff < CNT_W'(WINDOW_MAX)) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               arrival_in = arrival_nxt;
               seen_in    = seen_nxt;
               res_max_in = win_ok ? best : '0;
               res_ok_in  = win_ok;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = res_max_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clear) begin
         head_in    = '0;
         count_in   = '0;
         arrival_in = '0;
         seen_in    = '0;
         run_in     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         arrival_ff   <= '0;
         seen_ff      <= '0;
         run_ff       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         arrival_ff   <= arrival_in;
         seen_ff      <= seen_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      headv_ff   <= headv_in;
      key_ff     <= key_in;
      res_max_ff <= res_max_in;
      res_ok_ff  <= res_ok_in;
      rsp_max_ff <= rsp_max_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_max   = rsp_max_ff;
   assign rsp_result_valid = rsp_ok_ff;

endmodule

[hdl/sldmx_check.sv]
// Port-level assertions for the sliding window maximum block, bound to the top level.
`include "sliding_window_maximum_assert.svh"

module sldmx_check #(
   parameter int SAMPLE_BITS = sldmx_pkg::SAMPLE_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [SAMPLE_BITS-1:0]       rsp_window_max,
   input logic                         rsp_result_valid
);

   // stalled item holds
   `SWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_window_max) && $stable(rsp_result_valid), "stalled rsp item changed")

   // invalid results carry zero
   `SWM_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && !rsp_result_valid, rsp_window_max == '0, "invalid result with nonzero max")

   // nothing comes out straight after reset
   `SWM_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "rsp item right after reset")

   // the input queue cannot be full right after reset
   `SWM_ASSERT_NOW(a_reset_open, clock, reset, $past(reset), !req_stall, "req stalled right after reset")

endmodule

bind sliding_window_maximum sldmx_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_sldmx_check (.*);

[test/tb_top.sv]
// Self-checking testbench for the sliding window maximum block.
`timescale 1ns / 1ps

module tb_top;
   import sldmx_pkg::*;

   localparam int SW = SAMPLE_BITS_DEF;

   typedef struct {
      logic [SW-1:0] peak;
      logic          ok;
   } peak_item_type;

   // Expected window maximum per accepted item, and the check of each result.
   class peak_tracker;
      int unsigned              span;
      logic signed [SW-1:0]     recent[$];
      logic signed [SW-1:0]     running_peak;
      bit                       seen_any;
      peak_item_type            expected_peaks[$];
      int unsigned              mismatch_count;

      function new();
         span = LEN_RESET;
         mismatch_count = 0;
         restart();
      endfunction

      function void restart();
         recent.delete();
         seen_any = 1'b0;
      endfunction

      function void set_length(logic [LEN_W-1:0] len);
         span = (len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : len;
         restart();
      endfunction

      function int unsigned pending();
         return expected_peaks.size();
      endfunction

      function void take_sample(logic signed [SW-1:0] s, logic warm, logic first);
         peak_item_type e;
         logic signed [SW-1:0] best;
         if (first)
            restart();
         e.peak = '0;
         e.ok = 1'b0;
         if (!warm) begin
            if (span == 0) begin
               if (!seen_any || s > running_peak)
                  running_peak = s;
               seen_any = 1'b1;
               e.peak = running_peak;
               e.ok = 1'b1;
            end else begin
               recent.push_back(s);
               if (recent.size() > span)
                  void'(recent.pop_front());
               if (recent.size() == span) begin
                  best = recent[0];
                  foreach (recent[i])
                     if (recent[i] > best)
                        best = recent[i];
                  e.peak = best;
                  e.ok = 1'b1;
               end
            end
         end
         expected_peaks.push_back(e);
      endfunction

      function void note_error(string what);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: mismatch: %s", $realtime, what);
      endfunction

      function void check_peak(logic [SW-1:0] got_peak, logic got_ok);
         peak_item_type e;
         if (expected_peaks.size() == 0) begin
            note_error($sformatf("unexpected item window_max=%h result_valid=%b",
                                 got_peak, got_ok));
            return;
         end
         e = expected_peaks.pop_front();
         if (got_ok !== e.ok)
            note_error($sformatf("result_valid expected %b actual %b", e.ok, got_ok));
         if (got_peak !== e.peak)
            note_error($sformatf("window_max expected %h actual %h", e.peak, got_peak));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [SW-1:0]    req_sample = '0;
   logic             req_in_warmup = 1'b0;
   logic             req_first_of_series = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [SW-1:0]    rsp_window_max;
   logic             rsp_result_valid;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_window_length = '0;

   peak_tracker board = new();
   int  send_idle = 0;
   int  recv_idle = 0;
   bit  hold_go = 1'b0;
   logic long_hold = 1'b0;

   sliding_window_maximum i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .req_in_warmup       (req_in_warmup),
      .req_first_of_series (req_first_of_series),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_window_max      (rsp_window_max),
      .rsp_result_valid    (rsp_result_valid),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_window_length   (csr_window_length)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_peak(rsp_window_max, rsp_result_valid);
      rsp_stall <= long_hold || ($urandom_range(99) < recv_idle);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (300) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic send_item(input logic [SW-1:0] s, input logic warm, input logic first);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_in_warmup <= warm;
      req_first_of_series <= first;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.take_sample(s, warm, first);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      csr_window_length <= len;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      board.set_length(len);
   endtask

   function automatic logic [SW-1:0] next_sample(int style, logic [SW-1:0] prev);
      case (style)
         0: return $urandom();
         1: return $urandom_range(8) - 4;
         2: return prev - $urandom_range(1, 1000);
         3: return prev + $urandom_range(1, 1000);
         default: begin
            case ($urandom_range(3))
               0: return {1'b0, {(SW-1){1'b1}}};
               1: return {1'b1, {(SW-1){1'b0}}};
               2: return '0;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   task automatic run_phase(input logic [LEN_W-1:0] len, input int n, input bit hold_mid,
                            input bit pause_mid);
      int span;
      int made;
      int series_left;
      int style;
      int lead;
      bit first;
      bit warm;
      logic [SW-1:0] s;
      drain();
      write_length(len);
      span = (len == 0) ? 20 : ((len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : len);
      made = 0;
      s = $urandom();
      while (made < n) begin
         series_left = $urandom_range(span / 2 + 1, 3 * span + 10);
         style = $urandom_range(4);
         lead = $urandom_range(1) ? $urandom_range(1, 3) : 0;
         first = 1'b1;
         repeat (lead) begin
            send_item($urandom(), 1'b1, first);
            first = 1'b0;
         end
         for (int k = 0; k < series_left && made < n; k++) begin
            warm = ($urandom_range(99) < 4);
            s = next_sample(style, s);
            send_item(s, warm, first);
            first = 1'b0;
            if (!warm) begin
               made++;
               if (made == n / 2) begin
                  if (hold_mid)
                     hold_go = 1'b1;
                  if (pause_mid)
                     drain();
               end
            end
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short window
      send_idle = 34;
      recv_idle = 72;
      write_length(3);
      send_item(32'h1234_5678, 1'b1, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
      send_item(32'h8000_0000, 1'b0, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_item(32'h8000_0000, 1'b0, 1'b0);
      send_item(32'd5, 1'b0, 1'b0);
      send_item(32'd5, 1'b0, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
      send_item(32'd5, 1'b0, 1'b0);
      send_item(32'd100, 1'b0, 1'b0);
      send_item(32'd90, 1'b0, 1'b0);
      send_item(32'd80, 1'b0, 1'b0);
      send_item(32'd70, 1'b0, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_item(32'hFFFF_FFFE, 1'b0, 1'b0);
      send_item(32'hFFFF_FFFD, 1'b0, 1'b0);
      send_item(32'h0001_0000, 1'b1, 1'b1);
      // directed: cumulative
      drain();
      write_length(0);
      send_item(32'h8000_0000, 1'b0, 1'b1);
      send_item(32'hFFFF_FFFB, 1'b0, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_item(32'd3, 1'b0, 1'b0);
      send_item(32'd9, 1'b1, 1'b0);
      send_item(32'hFFFF_FFF9, 1'b0, 1'b1);
      send_item(32'h8000_0000, 1'b0, 1'b0);

      run_phase(2, 80, 1'b0, 1'b0);
      run_phase(1, 60, 1'b0, 1'b0);
      run_phase(5, 100, 1'b0, 1'b0);
      run_phase(0, 90, 1'b0, 1'b0);

      send_idle = 72;
      recv_idle = 34;
      run_phase(20, 130, 1'b0, 1'b0);
      run_phase(256, 340, 1'b0, 1'b0);
      run_phase(13, 90, 1'b0, 1'b1);
      run_phase(511, 300, 1'b0, 1'b0);

      send_idle = 0;
      recv_idle = 0;
      run_phase(64, 140, 1'b1, 1'b0);
      run_phase(3, 80, 1'b0, 1'b0);
      run_phase(0, 70, 1'b0, 1'b0);

      drain();
      repeat (20) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
